### src/vfdf_pkg.sv
// ----------------------------------------------------------------------------
// vfdf_pkg - shared types and constants of the divergence filter
// Register map, field widths and defaults used by the channel interfaces and
// the filter top level.
// ----------------------------------------------------------------------------
package vfdf_pkg;

	// default build values
	localparam int MAX_WIDTH_DEF      = 1024;
	localparam int COMPONENT_BITS_DEF = 16;

	// frame geometry
	localparam int MAX_HEIGHT = 1024;
	localparam int ROW_W      = 10;
	localparam int DIM_W      = 11;

	// output and configuration widths
	localparam int PIX_W      = 16;
	localparam int RANGE_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// mid-gray level that zero divergence maps to
	localparam int CENTER_LEVEL = 128;

	// register reset values
	localparam logic [RANGE_W-1:0] RANGE_RST  = 16'd255;
	localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd640;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTENSITY_RANGE = 2'd0,
		CFG_FRAME_WIDTH     = 2'd1,
		CFG_FRAME_HEIGHT    = 2'd2
	} cfg_reg_t;

endpackage

### src/vfdf_vec_if.sv
// ----------------------------------------------------------------------------
// vfdf_vec_if - vector input channel
// Valid/ready channel that carries one vector of the field per transfer.
// ----------------------------------------------------------------------------
interface vfdf_vec_if #(
	parameter int COMPONENT_BITS = vfdf_pkg::COMPONENT_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic                             start_of_frame;
	logic signed [COMPONENT_BITS-1:0] vec_x;
	logic signed [COMPONENT_BITS-1:0] vec_y;

	modport source (
		output valid, start_of_frame, vec_x, vec_y,
		input  ready
	);

	modport sink (
		input  valid, start_of_frame, vec_x, vec_y,
		output ready
	);
endinterface

### src/vfdf_pix_if.sv
// ----------------------------------------------------------------------------
// vfdf_pix_if - divergence pixel output channel
// Valid/ready channel that carries one scalar pixel per transfer.
// ----------------------------------------------------------------------------
interface vfdf_pix_if;
	import vfdf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             interior;
	logic             last_of_frame;

	modport source (
		output valid, pixel_value, interior, last_of_frame,
		input  ready
	);

	modport sink (
		input  valid, pixel_value, interior, last_of_frame,
		output ready
	);
endinterface

### src/vector_field_divergence_filter_top.sv
// ----------------------------------------------------------------------------
// vector_field_divergence_filter_top - streaming 2D divergence filter
// Central-difference divergence of a raster-order vector field, scaled,
// centered at 128 and saturated to the programmed intensity range.
// ----------------------------------------------------------------------------
// The filter takes one vector per clock and runs a four-stage pipeline: the
// input transfer issues the line store reads, the next stage forms the central
// difference sum, then comes the scale multiply, then round and saturate into
// the output register. Results pass through the stage 1, 2 and 3 registers
// into the output register; the result for pixel (r-1, c) is produced by
// input (r, c), so each pixel comes out one row late; row 0 inputs give no
// result and the bottom row is never emitted. Throughput is one vector per
// clock; the input is stalled when a result reaches the last stage while the
// output register still holds one that the sink has not taken. The
// previous-row vec_x lives in one RAM and the vec_y of the two previous rows
// share a second RAM of paired words. After reset a clearing pass zeroes both
// line stores, one entry per cycle, MAX_WIDTH entries (1024 by default),
// and the input is not ready until it ends. Border pixels come out as 0 with
// interior low.
// ----------------------------------------------------------------------------
module vector_field_divergence_filter_top #(
	parameter int MAX_WIDTH      = vfdf_pkg::MAX_WIDTH_DEF,
	parameter int COMPONENT_BITS = vfdf_pkg::COMPONENT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [vfdf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vfdf_pkg::CFG_DATA_W-1:0]  cfg_data,
	vfdf_vec_if.sink                         vec_in,
	vfdf_pix_if.source                       pix_out
);
	import vfdf_pkg::*;

	localparam int CB  = COMPONENT_BITS;
	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int SW  = CB + 2;
	localparam int MW  = CB + 1;
	localparam int PW  = MW + RANGE_W;
	localparam int LW  = PW + 2;
	localparam logic [PW:0] ROUND_BIAS = {{PW{1'b0}}, 1'b1} << (CB - 2);

	// configuration registers
	logic [RANGE_W-1:0] intensity_range_q;
	logic [DIM_W-1:0]   frame_width_q;
	logic [DIM_W-1:0]   frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_range_q <= RANGE_RST;
			frame_width_q     <= WIDTH_RST;
			frame_height_q    <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_INTENSITY_RANGE: intensity_range_q <= cfg_data[RANGE_W-1:0];
				CFG_FRAME_WIDTH:     frame_width_q     <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT:    frame_height_q    <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry and range
	logic [31:0]        fw32, fh32, w32, h32;
	logic [WCW-1:0]     w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic [RANGE_W-1:0] range_eff;
	logic [RANGE_W-1:0] range_m1;

	always_comb begin
		fw32 = 32'(frame_width_q);
		fh32 = 32'(frame_height_q);
		if (fw32 < 32'd3) begin
			w32 = 32'd3;
		end else if (fw32 > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end else begin
			w32 = fw32;
		end
		if (fh32 < 32'd3) begin
			h32 = 32'd3;
		end else if (fh32 > 32'(MAX_HEIGHT)) begin
			h32 = 32'(MAX_HEIGHT);
		end else begin
			h32 = fh32;
		end
		w_eff     = w32[WCW-1:0];
		h_eff     = h32[DIM_W-1:0];
		range_eff = (intensity_range_q == '0) ? RANGE_W'(1) : intensity_range_q;
		range_m1  = range_eff - RANGE_W'(1);
	end

	// line store clearing pass after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// handshake and pipeline enable
	logic v_s1, v_s2, v_s3;
	logic out_valid_q;
	logic en;
	logic acc;

	assign en           = !(v_s3 && out_valid_q && !pix_out.ready);
	assign vec_in.ready = en && !clr_busy_q;
	assign acc          = vec_in.valid && vec_in.ready;

	// position counters
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [WCW-1:0]   c_pre;
	logic [DIM_W-1:0] r_pre;
	logic [AW-1:0]    col;
	logic [ROW_W-1:0] row;
	logic [WCW-1:0]   col_p1;
	logic [DIM_W-1:0] row_p1;
	logic [AW-1:0]    col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic             right_ok, inner, last, emit;

	always_comb begin
		c_pre = vec_in.start_of_frame ? '0 : WCW'(col_q);
		r_pre = vec_in.start_of_frame ? '0 : DIM_W'(row_q);
		// shrunken geometry: move past the end of the row
		if (c_pre >= w_eff) begin
			c_pre = '0;
			r_pre = r_pre + DIM_W'(1);
		end
		if (r_pre >= h_eff) begin
			r_pre = '0;
		end
		col      = c_pre[AW-1:0];
		row      = r_pre[ROW_W-1:0];
		col_p1   = WCW'(col) + WCW'(1);
		row_p1   = DIM_W'(row) + DIM_W'(1);
		right_ok = col_p1 < w_eff;
		inner    = (row >= ROW_W'(2)) && (col != '0) && right_ok;
		last     = (DIM_W'(row) == h_eff - DIM_W'(1)) && (col_p1 == w_eff);
		emit     = row != '0;
		if (col_p1 >= w_eff) begin
			col_nxt = '0;
			row_nxt = (row_p1 >= h_eff) ? '0 : row_p1[ROW_W-1:0];
		end else begin
			col_nxt = col_p1[AW-1:0];
			row_nxt = row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// line stores
	logic signed [CB-1:0] hmem [MAX_WIDTH];
	logic [2*CB-1:0]      vmem [MAX_WIDTH];
	logic signed [CB-1:0] hrd_s1;
	logic [2*CB-1:0]      vrd_s1;
	logic [AW-1:0]        h_raddr;

	logic [AW-1:0]        col_s1;
	logic                 col0_s1, rok_s1, inner_s1, last_s1, emit_s1;
	logic signed [CB-1:0] vy_s1, h0_s1;
	logic                 fwd_s1;
	logic [2*CB-1:0]      fwd_data_s1;
	logic signed [CB-1:0] h0_q;
	logic signed [CB-1:0] prev_left_q, prev_here_q;

	logic [2*CB-1:0]      vold;
	logic signed [CB-1:0] near_old, far_old;
	logic signed [CB-1:0] right, here;
	logic signed [SW-1:0] sum;

	assign h_raddr = col_p1[AW-1:0];

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			hmem[clr_addr_q] <= '0;
		end else if (acc) begin
			hmem[col] <= vec_in.vec_x;
		end
		if (acc) begin
			hrd_s1 <= hmem[h_raddr];
		end
	end

	// each word pairs {previous row vec_y, vec_y two rows up}
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			vmem[clr_addr_q] <= '0;
		end else if (en && v_s1) begin
			vmem[col_s1] <= {vy_s1, near_old};
		end
		if (acc) begin
			vrd_s1 <= vmem[col];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1      <= col;
			col0_s1     <= col == '0;
			rok_s1      <= right_ok;
			inner_s1    <= inner;
			last_s1     <= last;
			emit_s1     <= emit;
			vy_s1       <= vec_in.vec_y;
			h0_s1       <= h0_q;
			// bypass the word that stage 1 writes at this same edge
			fwd_s1      <= v_s1 && (col_s1 == col);
			fwd_data_s1 <= {vy_s1, near_old};
		end
	end

	always_comb begin
		vold     = fwd_s1 ? fwd_data_s1 : vrd_s1;
		near_old = vold[2*CB-1:CB];
		far_old  = vold[CB-1:0];
		right    = rok_s1 ? hrd_s1 : '0;
		here     = col0_s1 ? h0_s1 : prev_here_q;
		sum      = SW'(right) - SW'(prev_left_q) + SW'(vy_s1) - SW'(far_old);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_q        <= '0;
			prev_left_q <= '0;
			prev_here_q <= '0;
		end else begin
			if (acc && (col == '0)) begin
				h0_q <= vec_in.vec_x;
			end
			if (en && v_s1) begin
				prev_left_q <= here;
				prev_here_q <= right;
			end
		end
	end

	// scale stage
	logic signed [SW-1:0] sum_s2;
	logic                 inner_s2, last_s2;
	logic                 neg;
	logic [SW-1:0]        abs_full;
	logic [MW-1:0]        mag;
	logic [PW-1:0]        prod;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2   <= sum;
			inner_s2 <= inner_s1;
			last_s2  <= last_s1;
		end
	end

	always_comb begin
		neg      = sum_s2[SW-1];
		abs_full = neg ? SW'(-sum_s2) : SW'(sum_s2);
		mag      = abs_full[MW-1:0];
		prod     = PW'(mag) * PW'(range_m1);
	end

	// round and saturate stage
	logic [PW-1:0]    prod_s3;
	logic             neg_s3, inner_s3, last_s3;
	logic [PW:0]      rounded;
	logic [PW:0]      q;
	logic [LW-1:0]    lvl;
	logic [PIX_W-1:0] pix;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3  <= prod;
			neg_s3   <= neg;
			inner_s3 <= inner_s2;
			last_s3  <= last_s2;
		end
	end

	always_comb begin
		rounded = (PW+1)'(prod_s3) + ROUND_BIAS;
		q       = rounded >> (CB - 1);
		if (neg_s3) begin
			lvl = (q >= (PW+1)'(CENTER_LEVEL)) ? '0 : LW'(CENTER_LEVEL) - LW'(q);
		end else begin
			lvl = LW'(CENTER_LEVEL) + LW'(q);
		end
		if (lvl > LW'(range_eff)) begin
			lvl = LW'(range_eff);
		end
		pix = inner_s3 ? lvl[PIX_W-1:0] : '0;
	end

	// stage valids: only items that produce a result go past stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
		end
	end

	// output register
	logic [PIX_W-1:0] pix_q;
	logic             interior_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && v_s3) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s3) begin
			pix_q      <= pix;
			interior_q <= inner_s3;
			last_q     <= last_s3;
		end
	end

	assign pix_out.valid         = out_valid_q;
	assign pix_out.pixel_value   = pix_q;
	assign pix_out.interior      = interior_q;
	assign pix_out.last_of_frame = last_q;

	// input is held back only by the clearing pass or a pending result that cannot move
	a_stall_only_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		!vec_in.ready |-> (clr_busy_q || (pix_out.valid && !pix_out.ready && v_s3)))
		else $error("input stalled without a blocked result");

	// last pixel of a frame sits in the right border column
	a_last_is_border: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.last_of_frame) |-> !pix_out.interior)
		else $error("last pixel of frame flagged interior");

	// border pixels read as zero
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.interior) |-> (pix_out.pixel_value == '0))
		else $error("border pixel with nonzero value");

endmodule

### dv/vfdf_divergence_check.sv
// ----------------------------------------------------------------------------
// vfdf_divergence_check - prediction and comparison for the divergence filter
// Watches the register port and both channels. Every vector transfer runs
// through a bit-exact model of the line stores and position counters. Each
// pixel transfer is checked field by field against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module vfdf_divergence_check
	import vfdf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vfdf_vec_if                   vec_mon,
	vfdf_pix_if                   pix_mon,
	output int                    mismatches,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB          = COMPONENT_BITS_DEF;
	localparam int STORE_DEPTH = MAX_WIDTH_DEF;
	localparam int FRAC_SHIFT  = CB - 1;
	localparam longint unsigned ROUND_BIAS = 64'd1 << (CB - 2);

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             interior;
		logic             last_of_frame;
	} pixel_t;

	logic [RANGE_W-1:0] range_reg;
	logic [DIM_W-1:0]   width_reg;
	logic [DIM_W-1:0]   height_reg;

	logic [CB-1:0] vx_row      [STORE_DEPTH];
	logic [CB-1:0] vy_row_near [STORE_DEPTH];
	logic [CB-1:0] vy_row_far  [STORE_DEPTH];
	int unsigned   col_pos;
	int unsigned   row_pos;
	logic [CB-1:0] left_vx;
	logic [CB-1:0] centre_vx;

	pixel_t expected_pixels[$];
	int     errors;
	int     pixel_count;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] pixel %0d: %s is %0d, expected %0d", $realtime, pixel_count, what,
			got, want);
		errors++;
	endtask

	// scale by (top - 1) / 2^(CB-1), round half away from zero, center and clip
	function automatic logic [PIX_W-1:0] scale_divergence(input longint sum,
			input longint unsigned top);
		longint unsigned mag;
		longint unsigned q;
		longint          level;
		mag = (sum < 0 ? -sum : sum);
		mag = mag * (top - 1);
		q = (mag + ROUND_BIAS) >> FRAC_SHIFT;
		level = sum < 0 ? CENTER_LEVEL - longint'(q) : CENTER_LEVEL + longint'(q);
		if (level < 0)
			level = 0;
		if (level > longint'(top))
			level = longint'(top);
		return level[PIX_W-1:0];
	endfunction

	task automatic advance_divergence(input logic sof, input logic [CB-1:0] vx,
			input logic [CB-1:0] vy);
		int unsigned        w;
		int unsigned        h;
		int unsigned        col;
		int unsigned        row;
		logic [RANGE_W-1:0] top;
		logic [CB-1:0]      here;
		logic [CB-1:0]      right;
		logic [CB-1:0]      above;
		longint             sum;
		pixel_t             px;
		w = width_reg < 3 ? 3 : (width_reg > STORE_DEPTH ? STORE_DEPTH : width_reg);
		h = height_reg < 3 ? 3 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
		top = range_reg == 0 ? 1 : range_reg;

		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		// a shrunken geometry pushes the position into the next row or frame
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		col = col_pos;
		row = row_pos;

		here = (col == 0) ? vx_row[0] : centre_vx;
		right = (col + 1 < w) ? vx_row[col + 1] : '0;
		above = vy_row_far[col];

		// the pixel one row up is complete once its lower neighbour arrives
		if (row >= 1) begin
			px.interior = row >= 2 && col >= 1 && col + 2 <= w;
			px.pixel_value = '0;
			if (px.interior) begin
				sum = longint'($signed(right)) - longint'($signed(left_vx))
					+ longint'($signed(vy)) - longint'($signed(above));
				px.pixel_value = scale_divergence(sum, top);
			end
			px.last_of_frame = row == h - 1 && col == w - 1;
			expected_pixels.push_back(px);
		end

		vx_row[col] = vx;
		vy_row_far[col] = vy_row_near[col];
		vy_row_near[col] = vy;
		left_vx = here;
		centre_vx = right;

		col_pos = col + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = row + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			range_reg = RANGE_RST;
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				vx_row[i] = '0;
				vy_row_near[i] = '0;
				vy_row_far[i] = '0;
			end
			col_pos = 0;
			row_pos = 0;
			left_vx = '0;
			centre_vx = '0;
			expected_pixels.delete();
			errors = 0;
			pixel_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INTENSITY_RANGE: range_reg = cfg_data[RANGE_W-1:0];
					CFG_FRAME_WIDTH:     width_reg = cfg_data[DIM_W-1:0];
					CFG_FRAME_HEIGHT:    height_reg = cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end

			if (pix_mon.valid && pix_mon.ready) begin
				pixel_count++;
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected pixel, value", 32'(pix_mon.pixel_value), 0);
				end else begin
					want = expected_pixels.pop_front();
					if (pix_mon.pixel_value !== want.pixel_value)
						report_mismatch("pixel_value", 32'(pix_mon.pixel_value),
							32'(want.pixel_value));
					if (pix_mon.interior !== want.interior)
						report_mismatch("interior", 32'(pix_mon.interior), 32'(want.interior));
					if (pix_mon.last_of_frame !== want.last_of_frame)
						report_mismatch("last_of_frame", 32'(pix_mon.last_of_frame),
							32'(want.last_of_frame));
				end
			end

			if (vec_mon.valid && vec_mon.ready)
				advance_divergence(vec_mon.start_of_frame, vec_mon.vec_x, vec_mon.vec_y);

			mismatches <= errors;
			pending <= expected_pixels.size();
		end
	end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb - regression for the vector field divergence filter
// Directed frames hit saturation at both ends, clamped registers and an
// unmapped register index; then random frames, broken frames and stray frame
// starts run under several geometries, including the widest and a mid-frame
// shrink of width and height, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vfdf_pkg::*;

	localparam int CB           = COMPONENT_BITS_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_ITEMS  = 100;
	localparam int PAUSE_PHASE  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
	localparam logic [CB-1:0] COMP_MIN = {1'b1, {(CB - 1){1'b0}}};
	localparam logic [CB-1:0] COMP_MAX = {1'b0, {(CB - 1){1'b1}}};

	// 3 x 4 frame: pixel (1,1) clips high, pixel (2,1) clips low
	localparam logic [CB-1:0] CLIP_VX [12] = '{
		'0, '0, '0,
		COMP_MIN, '0, COMP_MAX,
		COMP_MAX, '0, COMP_MIN,
		'0, '0, '0
	};
	localparam logic [CB-1:0] CLIP_VY [12] = '{
		'0, COMP_MIN, '0,
		'0, COMP_MAX, '0,
		'0, COMP_MAX, '0,
		'0, COMP_MIN, '0
	};

	typedef enum {LEAD_SOF, NO_SOF, STRAY_SOF} sof_plan_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pending_pixels;
	bit                    steady;
	int unsigned           width_now;
	int unsigned           height_now;

	vfdf_vec_if #(.COMPONENT_BITS(CB)) vec_ch ();
	vfdf_pix_if pix_ch ();

	vector_field_divergence_filter_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vec_in    (vec_ch),
		.pix_out   (pix_ch)
	);

	vfdf_divergence_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.vec_mon    (vec_ch),
		.pix_mon    (pix_ch),
		.mismatches (mismatches),
		.pending    (pending_pixels)
	);

	always #10 clk = ~clk;

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// junk in the unused upper bits of the geometry registers
	task automatic set_geometry(input int unsigned top, input int unsigned w,
			input int unsigned h);
		logic [CFG_DATA_W-1:0] word;
		write_reg(CFG_INTENSITY_RANGE, CFG_DATA_W'(top));
		word = $urandom;
		word[DIM_W-1:0] = DIM_W'(w);
		write_reg(CFG_FRAME_WIDTH, word);
		word = $urandom;
		word[DIM_W-1:0] = DIM_W'(h);
		write_reg(CFG_FRAME_HEIGHT, word);
		width_now = w < 3 ? 3 : (w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : w);
		height_now = h < 3 ? 3 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
	endtask

	// hold the input until every predicted pixel is out, then wait hold cycles
	task automatic settle(input int hold);
		vec_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_pixels != 0);
		repeat (hold) @(posedge clk);
	endtask

	function automatic logic [CB-1:0] pick_component();
		logic signed [CB-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0:       return COMP_MIN;
			1:       return COMP_MAX;
			2, 3, 4: return v;
			default: return v >>> $urandom_range(1, CB - 1);
		endcase
	endfunction

	task automatic send_vec(input logic sof, input logic [CB-1:0] vx,
			input logic [CB-1:0] vy);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			vec_ch.valid <= 1'b0;
			@(posedge clk);
		end
		vec_ch.valid <= 1'b1;
		vec_ch.start_of_frame <= sof;
		vec_ch.vec_x <= vx;
		vec_ch.vec_y <= vy;
		do @(posedge clk); while (!vec_ch.ready);
	endtask

	task automatic send_run(input int count, input sof_plan_t plan);
		logic sof;
		for (int i = 0; i < count; i++) begin
			case (plan)
				LEAD_SOF: sof = (i == 0);
				NO_SOF:   sof = 1'b0;
				default:  sof = ($urandom_range(0, 15) == 0);
			endcase
			send_vec(sof, pick_component(), pick_component());
		end
	endtask

	// output side: random stall before each transfer
	initial begin
		int stall;
		pix_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			repeat (stall) begin
				pix_ch.ready <= 1'b0;
				@(posedge clk);
			end
			pix_ch.ready <= 1'b1;
			do @(posedge clk); while (!pix_ch.valid);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("vector_field_divergence_filter_top regression: fail");
		$finish;
	end

	initial begin
		int        w;
		int        n;
		int        sent;
		int        kind;
		bit        first;
		bit        paused;
		sof_plan_t plan;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_INTENSITY_RANGE;
		cfg_data <= '0;
		vec_ch.valid <= 1'b0;
		vec_ch.start_of_frame <= 1'b0;
		vec_ch.vec_x <= '0;
		vec_ch.vec_y <= '0;
		steady = 1'b0;
		paused = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturation at both ends on the smallest width
		set_geometry(255, 3, 4);
		for (int i = 0; i < 12; i++)
			send_vec(i == 0, CLIP_VX[i], CLIP_VY[i]);
		settle(DRAIN_CYCLES);

		// out-of-range registers clamp; the spare index must change nothing
		write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
		set_geometry(0, $urandom_range(0, 2), $urandom_range(0, 2));
		send_run(9, LEAD_SOF);
		settle(DRAIN_CYCLES);

		// widest row, then shrink width and height without a frame start
		set_geometry(65535, $urandom_range(0, 1) ? MAX_WIDTH_DEF : 2047, MAX_HEIGHT);
		send_run(60, LEAD_SOF);
		settle(DRAIN_CYCLES);
		set_geometry(65535, 5, MAX_HEIGHT);
		send_run(25, NO_SOF);
		settle(DRAIN_CYCLES);
		set_geometry(65535, 5, 3);
		send_run(30, NO_SOF);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle(DRAIN_CYCLES);
			case ($urandom_range(0, 4))
				0:       n = 1;
				1:       n = 65535;
				2:       n = 255;
				default: n = $urandom_range(2, 65535);
			endcase
			w = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 48) : $urandom_range(3, 10);
			set_geometry(n, w, $urandom_range(3, 6));
			sent = 0;
			first = 1'b1;
			while (sent < PHASE_ITEMS) begin
				steady = ($urandom_range(0, 3) == 0);
				kind = $urandom_range(0, 9);
				// a frame start comes first after every geometry change
				if (first || kind < 6) begin
					n = width_now * height_now;
					plan = LEAD_SOF;
				end else if (kind < 8) begin
					n = $urandom_range(1, width_now * height_now - 1);
					plan = LEAD_SOF;
				end else if (kind == 8) begin
					n = width_now * height_now;
					plan = NO_SOF;
				end else begin
					n = $urandom_range(5, 20);
					plan = STRAY_SOF;
				end
				send_run(n, plan);
				sent += n;
				first = 1'b0;
				if (p == PAUSE_PHASE && !paused) begin
					settle(0);
					paused = 1'b1;
				end
			end
		end

		settle(DRAIN_CYCLES);
		if (mismatches == 0 && pending_pixels == 0)
			$display("vector_field_divergence_filter_top regression: pass");
		else
			$display("vector_field_divergence_filter_top regression: fail");
		$finish;
	end

endmodule
